// ----- hw/rtl/oht_pkg.sv -----
// Package: shared types, constants and codes of the object handle table.
`timescale 1ns / 1ps
package oht_pkg;

  localparam int unsigned DefSlots = 256;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_GET    = 2'd1,
    FUNC_SET    = 2'd2,
    FUNC_DELETE = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NULL      = 3'd1,
    ST_RANGE     = 3'd2,
    ST_TYPE      = 3'd3,
    ST_EXHAUSTED = 3'd4
  } status_e;

  localparam logic [CfgIdxW-1:0] REG_LOCAL_OWNER  = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_GLOBAL_OWNER = 1'd1;

  typedef struct packed {
    logic [1:0]  func;
    logic        gstore_sel;
    logic        is_null;
    logic [7:0]  type_code;
    logic [7:0]  handle_type;
    logic [7:0]  desc_owner;
    logic [15:0] obj_index;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] read_value;
    logic [7:0]  alloc_owner;
    logic [15:0] alloc_index;
    logic [7:0]  alloc_type;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RESP,
    S_OUT
  } state_e;

endpackage

// ----- hw/rtl/oht_ram.sv -----
// Generic RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module oht_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- hw/rtl/oht_finder.sv -----
// Occupancy vector per store and rotating priority search for a free slot.
`timescale 1ns / 1ps
module oht_finder #(
  parameter int unsigned Slots = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     upd_i,
  input  logic                     upd_global_i,
  input  logic [$clog2(Slots)-1:0] upd_idx_i,
  input  logic                     upd_full_i,
  input  logic                     sel_global_i,
  input  logic [$clog2(Slots)-1:0] start_i,
  output logic                     found_o,
  output logic [$clog2(Slots)-1:0] slot_o,
  output logic                     occ_o
);
  localparam int unsigned IdxW = $clog2(Slots);

  logic [Slots-1:0] gocc_q, locc_q;
  logic [Slots-1:0] occ, free_hi, free_lo;
  logic             hi_hit, lo_hit;
  logic [IdxW-1:0]  hi_idx, lo_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gocc_q <= '0;
      locc_q <= '0;
    end else if (upd_i) begin
      if (upd_global_i) gocc_q[upd_idx_i] <= upd_full_i;
      else locc_q[upd_idx_i] <= upd_full_i;
    end
  end

  // Occupancy of the slot addressed for update; an empty slot reads as zero.
  assign occ_o = upd_global_i ? gocc_q[upd_idx_i] : locc_q[upd_idx_i];

  // Split free slots at the start pointer, take the lowest at or above it first.
  always_comb begin
    occ = sel_global_i ? gocc_q : locc_q;
    for (int i = 0; i < Slots; i++) begin
      free_hi[i] = !occ[i] && (i >= int'(start_i));
      free_lo[i] = !occ[i];
    end
    hi_hit = 1'b0;
    lo_hit = 1'b0;
    hi_idx = '0;
    lo_idx = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (free_hi[i]) begin
        hi_hit = 1'b1;
        hi_idx = IdxW'(i);
      end
      if (free_lo[i]) begin
        lo_hit = 1'b1;
        lo_idx = IdxW'(i);
      end
    end
    found_o = lo_hit;
    slot_o  = hi_hit ? hi_idx : lo_idx;
  end
endmodule

// ----- hw/rtl/object_handle_table_core.sv -----
// Top level: object handle table with global and local stores.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/ready    | oht_pkg::req_t
//   rsp     | out       | rsp_valid/ready    | oht_pkg::rsp_t
//   cfg     | in        | cfg_we             | cfg_idx, cfg_wdata
//
// Each transaction passes S_READ and S_RESP from accept to result valid: the first
// searches the occupancy vector and issues the table read, the second takes
// the read data, writes back and forms the result into the output register.
// The next request is accepted in the cycle its predecessor's result is taken,
// so transactions do not overlap. Reset clears both occupancy vectors
// and pointers at once; a get of an empty slot reads zero through its
// occupancy bit, so the tables need no clearing pass.
// A stalled result holds in the output register and stalls the input.
`timescale 1ns / 1ps
module object_handle_table_core #(
  parameter int unsigned Slots = oht_pkg::DefSlots
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  oht_pkg::req_t                 req_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output oht_pkg::rsp_t                 rsp_o,
  input  logic                          cfg_we_i,
  input  logic [oht_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [oht_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import oht_pkg::*;

  localparam int unsigned IdxW = $clog2(Slots);

  state_e           state_q, state_d;
  req_t             req_q;
  rsp_t             rsp_q, rsp_d;
  logic [7:0]       lown_q, gown_q;
  logic [IdxW-1:0]  gnext_q, lnext_q, gnext_d, lnext_d;
  logic             glob_q, glob_d;      // store selected by the held request
  logic [IdxW-1:0]  slot_q, slot_d;
  logic             found_q, found_d;
  logic             range_ok;
  logic             found;
  logic [IdxW-1:0]  fslot;
  logic             slot_full;
  logic [IdxW-1:0]  slot_nxt;
  logic             we, upd;
  logic [63:0]      wdata;
  logic [63:0]      grd, lrd;
  logic [IdxW-1:0]  addr;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lown_q <= 8'd1;
      gown_q <= 8'd255;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_LOCAL_OWNER) lown_q <= cfg_wdata_i;
      else if (cfg_idx_i == REG_GLOBAL_OWNER) gown_q <= cfg_wdata_i;
    end
  end

  assign range_ok = (32'(req_q.obj_index) < Slots);

  // Advance the search pointer one past the taken slot, wrapping at the last slot.
  assign slot_nxt = (32'(slot_q) == Slots - 1) ? '0 : slot_q + 1'b1;

  oht_finder #(.Slots(Slots)) u_finder (
    .clk_i, .rst_ni,
    .upd_i        (upd),
    .upd_global_i (glob_q),
    .upd_idx_i    (slot_q),
    .upd_full_i   (wdata != '0),
    .sel_global_i (req_q.gstore_sel),
    .start_i      (req_q.gstore_sel ? gnext_q : lnext_q),
    .found_o      (found),
    .slot_o       (fslot),
    .occ_o        (slot_full)
  );

  assign addr = slot_d;

  oht_ram #(.Width(64), .Depth(Slots)) u_gtab (
    .clk_i, .we_i(we && glob_q), .waddr_i(slot_q), .wdata_i(wdata),
    .raddr_i(addr), .rdata_o(grd)
  );
  oht_ram #(.Width(64), .Depth(Slots)) u_ltab (
    .clk_i, .we_i(we && !glob_q), .waddr_i(slot_q), .wdata_i(wdata),
    .raddr_i(addr), .rdata_o(lrd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      gnext_q <= '0;
      lnext_q <= '0;
    end else begin
      state_q <= state_d;
      gnext_q <= gnext_d;
      lnext_q <= lnext_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) req_q <= req_i;
    glob_q  <= glob_d;
    slot_q  <= slot_d;
    found_q <= found_d;
    rsp_q   <= rsp_d;
  end

  always_comb begin
    state_d = state_q;
    gnext_d = gnext_q;
    lnext_d = lnext_q;
    glob_d  = glob_q;
    slot_d  = slot_q;
    found_d = found_q;
    rsp_d   = rsp_q;
    we      = 1'b0;
    upd     = 1'b0;
    wdata   = '0;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) state_d = S_READ;
      end
      S_READ: begin
        // Resolve store and slot, issue the read.
        if (req_q.func == FUNC_ALLOC) begin
          glob_d  = req_q.gstore_sel;
          slot_d  = fslot;
          found_d = found;
        end else begin
          glob_d  = (req_q.desc_owner == gown_q);
          slot_d  = req_q.obj_index[IdxW-1:0];
          found_d = range_ok;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        // Read data is valid now; write back and form the result.
        rsp_d = '0;
        case (req_q.func)
          FUNC_ALLOC: begin
            if (found_q) begin
              we = 1'b1;
              upd = 1'b1;
              wdata = req_q.value;
              rsp_d.alloc_owner = glob_q ? gown_q : lown_q;
              rsp_d.alloc_index = 16'(slot_q);
              rsp_d.alloc_type  = req_q.type_code;
              if (glob_q) gnext_d = slot_nxt;
              else lnext_d = slot_nxt;
            end else begin
              rsp_d.status = ST_EXHAUSTED;
            end
          end
          FUNC_GET: begin
            if (req_q.is_null) rsp_d.status = ST_NULL;
            else if (!found_q) rsp_d.status = ST_RANGE;
            else if (req_q.handle_type != req_q.type_code) rsp_d.status = ST_TYPE;
            else if (slot_full) rsp_d.read_value = glob_q ? grd : lrd;
          end
          default: begin
            if (!found_q) rsp_d.status = ST_RANGE;
            else begin
              we = 1'b1;
              upd = 1'b1;
              wdata = (req_q.func == FUNC_SET) ? req_q.value : '0;
            end
          end
        endcase
        state_d = S_OUT;
      end
      S_OUT: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          req_ready_o = 1'b1;
          state_d = req_valid_i ? S_READ : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rsp_o = rsp_q;
endmodule
